FILE: sv/cmi_pkg.sv
// shared types and constants for the checksum message interceptor
package cmi_pkg;

   // input mode codes
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // result kind codes
   localparam logic KIND_FWD   = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // frame header and opcode bytes
   localparam logic [7:0] HDR_CMD     = 8'h01;
   localparam logic [7:0] HDR_RESP    = 8'h02;
   localparam logic [7:0] HDR_EVENT   = 8'hEE;
   localparam logic [7:0] HDR_EVDATA  = 8'hED;
   localparam logic [7:0] OP_LONG     = 8'h01;
   localparam logic [7:0] OP_SHORT    = 8'h02;
   localparam logic [7:0] OP_LOG_EN   = 8'hF0;

   // frame lengths
   localparam logic [2:0] LEN_EVENT  = 3'd3;
   localparam logic [2:0] LEN_SHORT  = 3'd4;
   localparam logic [2:0] LEN_EVDATA = 3'd5;
   localparam logic [2:0] LEN_LONG   = 3'd7;

   localparam int          MAX_RESULTS   = 8;
   localparam logic [7:0]  IDLE_FLUSH_RST = 8'd20;

   typedef enum logic {
      ITEM_BYTE,
      ITEM_TICK
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    rx_byte;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [7:0]  event_id;
      logic [15:0] event_data;
      logic        event_has_data;
      logic [31:0] timestamp_ms;
      logic        link_connected;
   } result_type;

endpackage

FILE: sv/cmi_front.sv
// front end: accepts and classifies input items into a two-entry queue
module cmi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [7:0]        req_rx_byte,
   output logic              q_valid,
   output cmi_pkg::item_type q_item,
   input  logic              q_pop
);
   import cmi_pkg::*;

   item_type   entry_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in.kind    = (req_mode == MODE_TICK) ? ITEM_TICK : ITEM_BYTE;
      entry_in.rx_byte = req_rx_byte;
      wr_ptr_in        = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in        = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in           = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push)
      else $error("queue written while full");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("pop did not drain queue");
`endif

endmodule

FILE: sv/cmi_back.sv
// back end: frame store, parse sequencer and result register
module cmi_back #(
   parameter int MAX_FRAME_BYTES = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmi_pkg::item_type   q_item,
   output logic                q_pop,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   output cmi_pkg::result_type rsp_res,
   output logic                rsp_last,
   output logic                rsp_valid,
   input  logic                rsp_stall
);
   import cmi_pkg::*;

   localparam int   CW      = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic LONG_OK = (MAX_FRAME_BYTES >= 7);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_APPEND = 6'b000010,
      S_TICK   = 6'b000100,
      S_PARSE  = 6'b001000,
      S_FLUSH  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      P_KEEP,
      P_FAIL,
      P_ACCEPT
   } parse_type;

   state_type   state_ff, state_in;
   item_type    cur_ff, cur_in;
   logic [7:0]  held_ff [MAX_FRAME_BYTES];
   logic [7:0]  held_in [MAX_FRAME_BYTES];
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]  idle_ff, idle_in;
   logic [31:0] ms_ff, ms_in;
   logic        conn_ff, conn_in;
   logic [7:0]  cfg_ff, cfg_in;
   logic [3:0]  emit_cnt_ff, emit_cnt_in;
   result_type  pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   result_type  out_ff, out_in;
   logic        out_last_ff, out_last_in;
   logic        out_valid_ff, out_valid_in;

   logic [7:0]  hp [7];
   logic [7:0]  s2, s3, s4, s6;
   logic [2:0]  need;
   parse_type   pres;
   logic        gen;
   logic        gen_live;
   result_type  gen_res;
   result_type  fwd_res;
   result_type  evt_res;
   logic        out_free;
   logic        go;
   logic        out_load;
   logic        out_last;
   logic [7:0]  idle_inc;

   // padded view of the store for the checksum taps
   for (genvar g = 0; g < 7; g++) begin : g_pad
      if (g < MAX_FRAME_BYTES) begin : g_real
         assign hp[g] = held_ff[g];
      end else begin : g_zero
         assign hp[g] = 8'h00;
      end
   end

   assign s2 = hp[0] + hp[1];
   assign s3 = s2 + hp[2];
   assign s4 = s3 + hp[3];
   assign s6 = s4 + hp[4] + hp[5];

   // frame classification on the held bytes
   always_comb begin
      pres = P_KEEP;
      need = LEN_EVENT;
      if (count_ff != '0) begin
         case (hp[0])
            HDR_CMD: begin
               if (count_ff < CW'(2)) begin
                  pres = P_KEEP;
               end else if (hp[1] == OP_LONG) begin
                  need = LEN_LONG;
                  pres = P_ACCEPT;
               end else if (hp[1] == OP_SHORT) begin
                  need = LEN_SHORT;
                  pres = P_ACCEPT;
               end else begin
                  pres = P_FAIL;
               end
            end
            HDR_RESP: begin
               if (count_ff < CW'(2)) begin
                  pres = P_KEEP;
               end else if (hp[1] == OP_LOG_EN) begin
                  need = LEN_SHORT;
                  pres = P_ACCEPT;
               end else begin
                  pres = P_FAIL;
               end
            end
            HDR_EVENT: begin
               need = LEN_EVENT;
               pres = P_ACCEPT;
            end
            HDR_EVDATA: begin
               need = LEN_EVDATA;
               pres = P_ACCEPT;
            end
            default: pres = P_FAIL;
         endcase
         // checksum test once the frame length is known
         if (pres == P_ACCEPT) begin
            if (count_ff < CW'(need) || (need == LEN_LONG && !LONG_OK)) begin
               pres = P_KEEP;
            end else begin
               case (need)
                  LEN_EVENT:  pres = (s2 == hp[2]) ? P_ACCEPT : P_FAIL;
                  LEN_SHORT:  pres = (s3 == hp[3]) ? P_ACCEPT : P_FAIL;
                  LEN_EVDATA: pres = (s4 == hp[4]) ? P_ACCEPT : P_FAIL;
                  LEN_LONG:   pres = (s6 == hp[6]) ? P_ACCEPT : P_FAIL;
                  default:    pres = P_FAIL;
               endcase
            end
         end
      end
   end

   always_comb begin
      fwd_res                = '0;
      fwd_res.kind           = KIND_FWD;
      fwd_res.out_byte       = hp[0];
      fwd_res.link_connected = conn_ff;
      evt_res                = '0;
      evt_res.kind           = KIND_EVENT;
      evt_res.event_id       = hp[1];
      evt_res.timestamp_ms   = ms_ff;
      evt_res.link_connected = conn_ff;
      if (hp[0] == HDR_EVDATA) begin
         evt_res.event_data     = {hp[2], hp[3]};
         evt_res.event_has_data = 1'b1;
      end
   end

   // which step produces a result this cycle
   always_comb begin
      gen     = 1'b0;
      gen_res = fwd_res;
      case (state_ff)
         S_APPEND: gen = (count_ff >= CW'(MAX_FRAME_BYTES));
         S_FLUSH:  gen = 1'b1;
         S_PARSE: begin
            if (pres == P_FAIL) begin
               gen = 1'b1;
            end else if (pres == P_ACCEPT &&
                         (hp[0] == HDR_EVENT || hp[0] == HDR_EVDATA)) begin
               gen     = 1'b1;
               gen_res = evt_res;
            end
         end
         default: gen = 1'b0;
      endcase
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign gen_live = gen && (emit_cnt_ff < 4'(MAX_RESULTS));
   assign go       = !gen_live || !pend_valid_ff || out_free;
   assign idle_inc = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      held_in       = held_ff;
      count_in      = count_ff;
      idle_in       = idle_ff;
      ms_in         = ms_ff;
      conn_in       = conn_ff;
      cfg_in        = csr_wr_en ? csr_wr_data : cfg_ff;
      emit_cnt_in   = emit_cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      q_pop         = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cur_in      = q_item;
               emit_cnt_in = 4'd0;
               state_in    = (q_item.kind == ITEM_TICK) ? S_TICK : S_APPEND;
            end
         end
         S_APPEND: begin
            idle_in = 8'd0;
            if (go) begin
               if (count_ff >= CW'(MAX_FRAME_BYTES)) begin
                  // store full: oldest goes out, new byte lands at the top
                  for (int i = 0; i < MAX_FRAME_BYTES - 1; i++) begin
                     held_in[i] = held_ff[i + 1];
                  end
                  held_in[MAX_FRAME_BYTES - 1] = cur_ff.rx_byte;
               end else begin
                  for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
                     if (count_ff == CW'(i)) begin
                        held_in[i] = cur_ff.rx_byte;
                     end
                  end
                  count_in = count_ff + CW'(1);
               end
               state_in = S_PARSE;
            end
         end
         S_TICK: begin
            ms_in   = ms_ff + 32'd1;
            idle_in = idle_inc;
            if (count_ff != '0 && idle_inc > cfg_ff) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FLUSH, S_PARSE: begin
            if (go) begin
               if (state_ff == S_PARSE && pres == P_KEEP) begin
                  state_in = S_FINISH;
               end else if (state_ff == S_PARSE && pres == P_ACCEPT) begin
                  if (hp[0] == HDR_RESP) begin
                     conn_in = (hp[2] != 8'h00);
                  end
                  count_in = '0;
                  state_in = S_FINISH;
               end else begin
                  for (int i = 0; i < MAX_FRAME_BYTES - 1; i++) begin
                     held_in[i] = held_ff[i + 1];
                  end
                  count_in = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a new result pushes the pending one out with last low
      if (gen_live && go) begin
         if (pend_valid_ff) begin
            out_load = 1'b1;
            out_last = 1'b0;
         end
         pend_in       = gen_res;
         pend_valid_in = 1'b1;
         emit_cnt_in   = emit_cnt_ff + 4'd1;
      end
   end

   always_comb begin
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (out_load) begin
         out_in       = pend_ff;
         out_last_in  = out_last;
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_res   = out_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      held_ff     <= held_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         idle_ff       <= 8'd0;
         ms_ff         <= 32'd0;
         conn_ff       <= 1'b0;
         cfg_ff        <= IDLE_FLUSH_RST;
         emit_cnt_ff   <= 4'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idle_ff       <= idle_in;
         ms_ff         <= ms_in;
         conn_ff       <= conn_in;
         cfg_ff        <= cfg_in;
         emit_cnt_ff   <= emit_cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && pend_valid_ff && out_free)
      |=> (out_valid_ff && out_last_ff))
      else $error("final result of an item not marked last");
   a_parse_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PARSE) |-> (count_ff != '0))
      else $error("parse step with empty store");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("result left pending between items");
   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= 4'(MAX_RESULTS))
      else $error("result count beyond limit");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_FRAME_BYTES))
      else $error("held byte count beyond store depth");
`endif

endmodule

FILE: sv/checksum_message_interceptor_top.sv
// top level of the checksum message interceptor
//
//  channel | direction | transfer when     | payload
//  req     | in        | req_valid & !stall | req_mode, req_rx_byte
//  rsp     | out       | rsp_valid & !stall | kind, byte, event fields, last
//  csr     | in        | csr_wr_en          | csr_wr_data (idle flush ticks)
//
// in the back-end sequencer a received byte is fetched, appended, parsed in
// one or more parse steps (each failed parse forwards one byte) and then
// closed; a tick is fetched, counted, flushes the held bytes one per step
// once the idle limit is passed, and is then closed.
// reset is synchronous and clears the store count, counters, flag and queue.
// rsp_stall holds the sequencer when a second result is ready or the item's
// last result waits to go out; the two-entry queue takes transfers until full.
module checksum_message_interceptor_top #(
   parameter int MAX_FRAME_BYTES = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_event_id,
   output logic [15:0] rsp_event_data,
   output logic        rsp_event_has_data,
   output logic [31:0] rsp_timestamp_ms,
   output logic        rsp_link_connected,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import cmi_pkg::*;

   logic       q_valid;
   item_type   q_item;
   logic       q_pop;
   result_type res;

   cmi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   cmi_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_res     (res),
      .rsp_last    (rsp_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall)
   );

   assign rsp_kind           = res.kind;
   assign rsp_out_byte       = res.out_byte;
   assign rsp_event_id       = res.event_id;
   assign rsp_event_data     = res.event_data;
   assign rsp_event_has_data = res.event_has_data;
   assign rsp_timestamp_ms   = res.timestamp_ms;
   assign rsp_link_connected = res.link_connected;

endmodule

FILE: tb/tb_checksum_message_interceptor_top.sv
// self-checking testbench for the checksum message interceptor top level
module tb_checksum_message_interceptor_top;
   import cmi_pkg::*;

   localparam int HOLD_DEPTH      = 7;
   localparam int SCAN_WAIT       = 0;
   localparam int SCAN_BAD        = -1;
   localparam int DRAIN_GAP       = 24;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 400000;

   typedef enum int {
      FR_LONG,
      FR_SHORT,
      FR_LOG_EN,
      FR_EVENT,
      FR_EVDATA
   } frame_shape_type;

   typedef struct packed {
      result_type res;
      logic       last;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = MODE_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [7:0]  rsp_event_id;
   logic [15:0] rsp_event_data;
   logic        rsp_event_has_data;
   logic [31:0] rsp_timestamp_ms;
   logic        rsp_link_connected;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   checksum_message_interceptor_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_event_id       (rsp_event_id),
      .rsp_event_data     (rsp_event_data),
      .rsp_event_has_data (rsp_event_has_data),
      .rsp_timestamp_ms   (rsp_timestamp_ms),
      .rsp_link_connected (rsp_link_connected),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // interceptor state as the testbench sees it
   logic [7:0]  held [HOLD_DEPTH];
   int          held_n = 0;
   logic [7:0]  idle_n = 8'd0;
   logic [31:0] ms_now = 32'd0;
   logic        linked = 1'b0;
   logic [7:0]  flush_after = IDLE_FLUSH_RST;

   item_type     pending [$];
   rsp_beat_type awaited [$];
   item_type     on_wire;
   int           queued_cnt = 0;
   int           accepted_cnt = 0;
   int           checked_cnt = 0;
   int           events_seen = 0;
   int           fails = 0;
   int           cycle_cnt = 0;
   int           send_gap_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_off_seq = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   function automatic void add_result(input logic kind, input logic [7:0] b,
                                      input logic [7:0] id, input logic [15:0] data,
                                      input logic has, input logic [31:0] ts);
      rsp_beat_type beat;
      beat.res.kind           = kind;
      beat.res.out_byte       = b;
      beat.res.event_id       = id;
      beat.res.event_data     = data;
      beat.res.event_has_data = has;
      beat.res.timestamp_ms   = ts;
      beat.res.link_connected = linked;
      beat.last               = 1'b0;
      awaited.push_back(beat);
   endfunction

   function automatic void pass_oldest();
      if (held_n == 0) return;
      add_result(KIND_FWD, held[0], 8'h00, 16'h0000, 1'b0, 32'd0);
      for (int i = 0; i + 1 < held_n; i++) held[i] = held[i + 1];
      held_n--;
   endfunction

   // frame length when the held bytes start with a good frame
   function automatic int frame_verdict();
      int         need;
      logic [7:0] csum;
      need = 0;
      csum = 8'h00;
      if (held_n < 1) return SCAN_WAIT;
      case (held[0])
         HDR_CMD: begin
            if (held_n < 2) return SCAN_WAIT;
            if (held[1] == OP_LONG) need = int'(LEN_LONG);
            else if (held[1] == OP_SHORT) need = int'(LEN_SHORT);
            else return SCAN_BAD;
         end
         HDR_RESP: begin
            if (held_n < 2) return SCAN_WAIT;
            if (held[1] != OP_LOG_EN) return SCAN_BAD;
            need = int'(LEN_SHORT);
         end
         HDR_EVENT:  need = int'(LEN_EVENT);
         HDR_EVDATA: need = int'(LEN_EVDATA);
         default:    return SCAN_BAD;
      endcase
      if (held_n < need || need > HOLD_DEPTH) return SCAN_WAIT;
      for (int i = 0; i + 1 < need; i++) csum = csum + held[i];
      return (csum == held[need - 1]) ? need : SCAN_BAD;
   endfunction

   function automatic void take_frame();
      case (held[0])
         HDR_RESP:   linked = (held[2] != 8'h00);
         HDR_EVENT:  add_result(KIND_EVENT, 8'h00, held[1], 16'h0000, 1'b0, ms_now);
         HDR_EVDATA: add_result(KIND_EVENT, 8'h00, held[1], {held[2], held[3]}, 1'b1, ms_now);
         default: ;
      endcase
      held_n = 0;
   endfunction

   function automatic void predict_item(input item_type it);
      int           verdict;
      int           n_before;
      rsp_beat_type tail;
      n_before = awaited.size();
      if (it.kind == ITEM_BYTE) begin
         idle_n = 8'd0;
         if (held_n >= HOLD_DEPTH) pass_oldest();
         held[held_n] = it.rx_byte;
         held_n++;
         while (held_n > 0) begin
            verdict = frame_verdict();
            if (verdict == SCAN_WAIT) break;
            if (verdict == SCAN_BAD) begin
               pass_oldest();
            end else begin
               take_frame();
               break;
            end
         end
      end else begin
         ms_now++;
         if (idle_n != 8'hFF) idle_n++;
         if (held_n > 0 && idle_n > flush_after) begin
            while (held_n > 0) pass_oldest();
         end
      end
      if (awaited.size() > n_before) begin
         tail = awaited.pop_back();
         tail.last = 1'b1;
         awaited.push_back(tail);
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic int tick_burst();
      return (flush_after < 8'd28) ? $urandom_range(1, int'(flush_after) + 2)
                                   : $urandom_range(1, 30);
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      item_type it;
      it.kind    = ITEM_BYTE;
      it.rx_byte = b;
      pending.push_back(it);
      queued_cnt++;
   endtask

   task automatic queue_ticks(input int n);
      item_type it;
      for (int i = 0; i < n; i++) begin
         it.kind    = ITEM_TICK;
         it.rx_byte = rand_byte();
         pending.push_back(it);
         queued_cnt++;
      end
   endtask

   // spoil flips one checksum bit so the frame cannot match
   task automatic send_frame(input frame_shape_type shape, input logic [7:0] a,
                             input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d, input logic spoil);
      logic [7:0] fb [HOLD_DEPTH];
      int         n;
      logic [7:0] csum;
      n = 0;
      csum = 8'h00;
      case (shape)
         FR_LONG: begin
            fb[0] = HDR_CMD; fb[1] = OP_LONG; fb[2] = a; fb[3] = b; fb[4] = c; fb[5] = d;
            n = int'(LEN_LONG);
         end
         FR_SHORT: begin
            fb[0] = HDR_CMD; fb[1] = OP_SHORT; fb[2] = a;
            n = int'(LEN_SHORT);
         end
         FR_LOG_EN: begin
            fb[0] = HDR_RESP; fb[1] = OP_LOG_EN; fb[2] = a;
            n = int'(LEN_SHORT);
         end
         FR_EVENT: begin
            fb[0] = HDR_EVENT; fb[1] = a;
            n = int'(LEN_EVENT);
         end
         default: begin
            fb[0] = HDR_EVDATA; fb[1] = a; fb[2] = b; fb[3] = c;
            n = int'(LEN_EVDATA);
         end
      endcase
      for (int i = 0; i + 1 < n; i++) begin
         csum = csum + fb[i];
         queue_byte(fb[i]);
      end
      queue_byte(spoil ? csum ^ (8'h01 << $urandom_range(7)) : csum);
   endtask

   task automatic random_traffic(input int n_items);
      int stop_at;
      int pick;
      stop_at = queued_cnt + n_items;
      while (queued_cnt < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_frame(frame_shape_type'($urandom_range(4)), rand_byte(), rand_byte(),
                       rand_byte(), rand_byte(), $urandom_range(9) == 0);
         end else if (pick < 65) begin
            // frame cut short, left for the idle flush or the next bytes
            if ($urandom_range(1)) begin
               queue_byte(HDR_EVDATA);
            end else begin
               queue_byte(HDR_CMD);
               queue_byte(OP_LONG);
            end
            queue_byte(rand_byte());
            queue_ticks(tick_burst());
         end else if (pick < 80) begin
            queue_byte(rand_byte());
         end else begin
            queue_ticks(tick_burst());
         end
      end
   endtask

   task automatic set_flush_limit(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      flush_after = v;
   endtask

   // every transfer in, every result out, then room for items with no result
   task automatic drain();
      while (accepted_cnt != queued_cnt || awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_item(on_wire);
            accepted_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               on_wire = pending.pop_front();
               req_valid   <= 1'b1;
               req_mode    <= (on_wire.kind == ITEM_TICK) ? MODE_TICK : MODE_BYTE;
               req_rx_byte <= on_wire.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_seq != hold_seen) begin
         hold_seen <= hold_off_seq;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_cnt++;
         if (rsp_kind == KIND_EVENT) events_seen++;
         if (awaited.size() == 0) begin
            $error("unexpected transfer: kind %0d byte %02h id %02h", rsp_kind, rsp_out_byte,
                   rsp_event_id);
            fails++;
         end else begin
            want = awaited.pop_front();
            if (rsp_kind !== want.res.kind) begin
               $error("kind: expected %0d, got %0d", want.res.kind, rsp_kind);
               fails++;
            end
            if (rsp_out_byte !== want.res.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.res.out_byte, rsp_out_byte);
               fails++;
            end
            if (rsp_event_id !== want.res.event_id) begin
               $error("event_id: expected %02h, got %02h", want.res.event_id, rsp_event_id);
               fails++;
            end
            if (rsp_event_data !== want.res.event_data) begin
               $error("event_data: expected %04h, got %04h", want.res.event_data,
                      rsp_event_data);
               fails++;
            end
            if (rsp_event_has_data !== want.res.event_has_data) begin
               $error("event_has_data: expected %0d, got %0d", want.res.event_has_data,
                      rsp_event_has_data);
               fails++;
            end
            if (rsp_timestamp_ms !== want.res.timestamp_ms) begin
               $error("timestamp_ms: expected %0d, got %0d", want.res.timestamp_ms,
                      rsp_timestamp_ms);
               fails++;
            end
            if (rsp_link_connected !== want.res.link_connected) begin
               $error("link_connected: expected %0d, got %0d", want.res.link_connected,
                      rsp_link_connected);
               fails++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
                  awaited.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed frames and corner cases, with ticks only for the final idle flush
      set_flush_limit(8'd1);
      send_frame(FR_EVDATA, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
      send_frame(FR_LOG_EN, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(FR_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(FR_LOG_EN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(FR_SHORT, 8'h5A, 8'h00, 8'h00, 8'h00, 1'b1);
      queue_byte(HDR_CMD);
      queue_byte(8'h03);
      send_frame(FR_LONG, 8'h00, 8'hFF, 8'h7F, 8'h80, 1'b0);
      // lone header held until the idle flush
      queue_byte(HDR_EVDATA);
      queue_ticks(2);
      drain();

      set_flush_limit(8'd0);
      send_gap_pct   = 32;
      recv_stall_pct = 64;
      random_traffic(80);
      drain();

      set_flush_limit(8'($urandom_range(2, 40)));
      send_gap_pct   = 64;
      recv_stall_pct = 32;
      random_traffic(80);
      drain();

      // receiver holds off while the sender keeps offering transfers
      set_flush_limit(8'd255);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      hold_off_seq <= hold_off_seq + 1;
      random_traffic(80);
      drain();

      // long idle run past the limit flushes whatever is held
      set_flush_limit(8'd30);
      queue_byte(HDR_EVENT);
      queue_ticks(40);
      send_frame(FR_EVENT, rand_byte(), 8'h00, 8'h00, 8'h00, 1'b0);
      drain();

      if (awaited.size() != 0) begin
         $error("%0d expected results never arrived", awaited.size());
         fails++;
      end
      $display("%0d bytes and ticks accepted, %0d results checked, %0d of them log events",
               accepted_cnt, checked_cnt, events_seen);
      $display("flush limits 1, 0, 30, 255 and one random value, with a long receiver hold-off");
      if (fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
